/* rtl/core/mbik_pkg.sv */
// ----------------------------------------------------------------------------
// Mobile base inverse kinematics: shared package
// Field widths, register codes and fixed-point constants used by the top level
// and the per-wheel datapath, plus the datapath's PWM full-scale helper.
// ----------------------------------------------------------------------------
package mbik_pkg;

    // Command and result fields
    localparam int VEL_W   = 14;
    localparam int TURN_W  = 16;
    localparam int RPM_W   = 14;
    localparam int DUTY_W  = 17;

    // Configuration registers
    localparam int MODE_W  = 2;
    localparam int MAX_W   = 13;
    localparam int BITS_W  = 5;
    localparam int GAIN_W  = 24;
    localparam int SPAN_W  = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Datapath widths
    localparam int LIN_W   = VEL_W + 1;             // x +- y
    localparam int TAN_W   = 28;                    // turn * half span
    localparam int INNER_W = 29;                    // 1000 * lin +- tan
    localparam int ACC_W   = INNER_W + GAIN_W;      // gain * inner
    localparam int MAG_W   = 23;                    // |acc| >> 16, clamped
    localparam int Q_W     = 14;                    // mag / 1000
    localparam int FULL_W  = 16;                    // PWM full scale
    localparam int NUM_W   = MAX_W + FULL_W;        // rpm * full scale

    localparam int Q16_SHIFT   = 16;
    localparam int MS_PER_S    = 1000;
    // ceil(2^33 / 1000): exact floor(m / 1000) for any m below 2^23
    localparam int RECIP_SHIFT = 33;
    localparam logic [GAIN_W-1:0] RECIP_1000 = 24'd8589935;
    localparam int PROD_W      = MAG_W + GAIN_W;

    localparam int DIV_STEPS_DEF = 4;               // quotient bits per stage

    typedef enum logic [MODE_W-1:0] {
        MODE_DIFFERENTIAL = 2'd0,
        MODE_SKID_STEER   = 2'd1,
        MODE_ACKERMANN    = 2'd2,
        MODE_MECANUM      = 2'd3
    } platform_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PLATFORM_MODE = 3'd0,
        REG_MAX_WHEEL_RPM = 3'd1,
        REG_PWM_BITS      = 3'd2,
        REG_RPM_GAIN      = 3'd3,
        REG_HALF_SPAN     = 3'd4
    } cfg_reg_t;

    // Settings every wheel needs
    typedef struct packed {
        logic [MAX_W-1:0]  max_rpm;
        logic [BITS_W-1:0] pwm_width;
        logic [GAIN_W-1:0] gain;
    } wheel_cfg_t;

    // 2^bits - 1, bits capped at sixteen
    function automatic logic [FULL_W-1:0] pwm_full(input logic [BITS_W-1:0] bits);
        logic [FULL_W-1:0] res;
        if (bits >= BITS_W'(FULL_W))
            res = '1;
        else
            res = FULL_W'((17'd1 << bits) - 17'd1);
        return res;
    endfunction

endpackage

/* rtl/core/mbik_wheel.sv */
// ----------------------------------------------------------------------------
// Mobile base inverse kinematics: one wheel
// Mixes linear and tangential speed, scales to RPM, saturates, then divides
// rpm * full scale by max RPM in a pipelined restoring divider.
// ----------------------------------------------------------------------------
module mbik_wheel
    import mbik_pkg::*;
#(
    parameter int DIV_STEPS = DIV_STEPS_DEF,
    parameter int NSTG      = FULL_W / DIV_STEPS + 7
)
(
    input  logic                     clk,
    input  logic [NSTG-1:0]          en,
    input  wheel_cfg_t               cfg,
    input  logic                     tan_sub,
    input  logic signed [LIN_W-1:0]  lin,
    input  logic signed [TAN_W-1:0]  tan,
    output logic signed [RPM_W-1:0]  rpm,
    output logic signed [DUTY_W-1:0] duty
);

    localparam int DIV_STAGES = FULL_W / DIV_STEPS;
    localparam int ST_INNER = 1;
    localparam int ST_ACC   = 2;
    localparam int ST_MAG   = 3;
    localparam int ST_QUO   = 4;
    localparam int ST_SAT   = 5;
    localparam int ST_DIV0  = 6;
    localparam int ST_OUT   = NSTG - 1;

    // one restoring step: {rem, num/quotient} -> shifted pair
    function automatic logic [NUM_W-1:0] div_step(input logic [NUM_W-1:0] rw,
                                                  input logic [MAX_W-1:0] d);
        logic [MAX_W:0] trial;
        logic [MAX_W:0] diff;
        logic [NUM_W-1:0] res;
        trial = {rw[NUM_W-1:FULL_W], rw[FULL_W-1]};
        diff  = trial - {1'b0, d};
        if (trial >= {1'b0, d})
            res = {diff[MAX_W-1:0], rw[FULL_W-2:0], 1'b1};
        else
            res = {trial[MAX_W-1:0], rw[FULL_W-2:0], 1'b0};
        return res;
    endfunction

    logic signed [INNER_W-1:0] inner_reg, inner_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [MAG_W-1:0]          mag_reg, mag_next;
    logic                      mag_neg_reg;
    logic [Q_W-1:0]            quo_reg, quo_next;
    logic                      quo_neg_reg;
    logic [MAX_W-1:0]          sat_reg, sat_next;
    logic [NUM_W-1:0]          num_reg, num_next;
    logic                      sat_neg_reg;
    logic [NUM_W-1:0]          div_rw_reg  [DIV_STAGES];
    logic [MAX_W-1:0]          div_sat_reg [DIV_STAGES];
    logic                      div_neg_reg [DIV_STAGES];
    logic signed [RPM_W-1:0]   rpm_reg, rpm_next;
    logic signed [DUTY_W-1:0]  duty_reg, duty_next;

    logic signed [INNER_W-1:0] lin_scaled;
    logic signed [INNER_W-1:0] tan_ext;
    logic signed [ACC_W:0]     acc_full;
    logic [ACC_W-1:0]          acc_abs;
    logic [ACC_W-Q16_SHIFT-1:0] acc_shr;
    logic [PROD_W-1:0]         recip_prod;
    logic [FULL_W-1:0]         full;

    // mix
    always_comb
    begin
        lin_scaled = INNER_W'(lin) * $signed(INNER_W'(MS_PER_S));
        tan_ext    = INNER_W'(tan);
        inner_next = tan_sub ? lin_scaled - tan_ext : lin_scaled + tan_ext;
    end

    // gain
    always_comb
    begin
        acc_full = inner_reg * $signed({1'b0, cfg.gain});
        acc_next = acc_full[ACC_W-1:0];
    end

    // magnitude in Q16 units, clamped well above any legal RPM
    always_comb
    begin
        acc_abs  = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        acc_shr  = acc_abs[ACC_W-1:Q16_SHIFT];
        mag_next = (|acc_shr[ACC_W-Q16_SHIFT-1:MAG_W]) ? '1 : acc_shr[MAG_W-1:0];
    end

    // divide by 1000 through the reciprocal
    always_comb
    begin
        recip_prod = mag_reg * RECIP_1000;
        quo_next   = recip_prod[PROD_W-1:RECIP_SHIFT];
    end

    // saturate, then scale to PWM counts
    always_comb
    begin
        full     = pwm_full(cfg.pwm_width);
        sat_next = (quo_reg > {1'b0, cfg.max_rpm}) ? cfg.max_rpm : quo_reg[MAX_W-1:0];
        num_next = sat_next * full;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_INNER])
        begin
            inner_reg <= inner_next;
        end
        if (en[ST_ACC])
        begin
            acc_reg <= acc_next;
        end
        if (en[ST_MAG])
        begin
            mag_reg     <= mag_next;
            mag_neg_reg <= acc_reg[ACC_W-1];
        end
        if (en[ST_QUO])
        begin
            quo_reg     <= quo_next;
            quo_neg_reg <= mag_neg_reg;
        end
        if (en[ST_SAT])
        begin
            sat_reg     <= sat_next;
            num_reg     <= num_next;
            sat_neg_reg <= quo_neg_reg;
        end
    end

    // rpm * full < max * 2^16, so the quotient fits sixteen bits and the
    // top bits of the numerator already form the first partial remainder
    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        logic [NUM_W-1:0] rw_src;
        logic [MAX_W-1:0] sat_src;
        logic             neg_src;
        logic [NUM_W-1:0] rw_next;

        if (g == 0)
        begin : g_first
            assign rw_src  = num_reg;
            assign sat_src = sat_reg;
            assign neg_src = sat_neg_reg;
        end
        else
        begin : g_rest
            assign rw_src  = div_rw_reg[g-1];
            assign sat_src = div_sat_reg[g-1];
            assign neg_src = div_neg_reg[g-1];
        end

        always_comb
        begin : p_steps
            logic [NUM_W-1:0] rw_v;
            rw_v = rw_src;
            for (int s = 0; s < DIV_STEPS; s++)
            begin
                rw_v = div_step(rw_v, cfg.max_rpm);
            end
            rw_next = rw_v;
        end

        always_ff @(posedge clk)
        begin
            if (en[ST_DIV0+g])
            begin
                div_rw_reg[g]  <= rw_next;
                div_sat_reg[g] <= sat_src;
                div_neg_reg[g] <= neg_src;
            end
        end
    end

    // restore signs; zero max RPM forces zero duty
    always_comb
    begin
        rpm_next  = div_neg_reg[DIV_STAGES-1]
                  ? -RPM_W'(div_sat_reg[DIV_STAGES-1])
                  :  RPM_W'(div_sat_reg[DIV_STAGES-1]);
        if (cfg.max_rpm == '0)
            duty_next = '0;
        else if (div_neg_reg[DIV_STAGES-1])
            duty_next = -DUTY_W'(div_rw_reg[DIV_STAGES-1][FULL_W-1:0]);
        else
            duty_next = DUTY_W'(div_rw_reg[DIV_STAGES-1][FULL_W-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            rpm_reg  <= rpm_next;
            duty_reg <= duty_next;
        end
    end

    assign rpm  = rpm_reg;
    assign duty = duty_reg;

endmodule

/* rtl/core/mobile_base_inverse_kinematics.sv */
// ----------------------------------------------------------------------------
// Mobile base inverse kinematics
// Body velocity command in, four wheel RPM targets and PWM duties out.
// ----------------------------------------------------------------------------
// Throughput: one command per cycle unless out_ready stalls the output; each
//   stage holds one beat and the divider retires DIV_STEPS_PER_STAGE
//   quotient bits per stage.
// Reset: rst_n clears the pipeline valid bits and loads the configuration
//   defaults (differential, 330 RPM, 8-bit PWM, gain 12516, 150 mm).
module mobile_base_inverse_kinematics
    import mbik_pkg::*;
#(
    parameter int DIV_STEPS_PER_STAGE = DIV_STEPS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_write,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,

    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [VEL_W-1:0]      velocity_x,
    input  logic signed [VEL_W-1:0]      velocity_y,
    input  logic signed [TURN_W-1:0]     turn_rate,

    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [RPM_W-1:0]      front_left_rpm,
    output logic signed [RPM_W-1:0]      front_right_rpm,
    output logic signed [RPM_W-1:0]      rear_left_rpm,
    output logic signed [RPM_W-1:0]      rear_right_rpm,
    output logic signed [DUTY_W-1:0]     front_left_duty,
    output logic signed [DUTY_W-1:0]     front_right_duty,
    output logic signed [DUTY_W-1:0]     rear_left_duty,
    output logic signed [DUTY_W-1:0]     rear_right_duty
);

    // Stage map (per wheel from stage 1 on):
    //   0      mode masking, x - y, x + y, turn * half span
    //   1      1000 * lin +- tan
    //   2      gain multiply
    //   3      magnitude, >> 16, clamp
    //   4      / 1000 by reciprocal multiply
    //   5      saturate to max RPM, multiply by PWM full scale
    //   6..    restoring divide by max RPM
    //   last   sign restore, output register
    localparam int DIV_STAGES = FULL_W / DIV_STEPS_PER_STAGE;
    localparam int NSTG       = DIV_STAGES + 7;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    platform_mode_t    mode_reg;
    logic [MAX_W-1:0]  max_rpm_reg;
    logic [BITS_W-1:0] pwm_width_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [SPAN_W-1:0] span_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_DIFFERENTIAL;
            max_rpm_reg   <= MAX_W'(330);
            pwm_width_reg <= BITS_W'(8);
            gain_reg      <= GAIN_W'(12516);
            span_reg      <= SPAN_W'(150);
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PLATFORM_MODE: mode_reg      <= platform_mode_t'(cfg_data[MODE_W-1:0]);
                REG_MAX_WHEEL_RPM: max_rpm_reg   <= cfg_data[MAX_W-1:0];
                REG_PWM_BITS:      pwm_width_reg <= cfg_data[BITS_W-1:0];
                REG_RPM_GAIN:      gain_reg      <= cfg_data[GAIN_W-1:0];
                REG_HALF_SPAN:     span_reg      <= cfg_data[SPAN_W-1:0];
                default:           ;
            endcase
        end
    end

    wheel_cfg_t wcfg;
    assign wcfg = '{max_rpm: max_rpm_reg, pwm_width: pwm_width_reg, gain: gain_reg};

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage takes a beat when it is empty or
    // its own beat moves on, so bubbles close up behind a stalled output
    // ------------------------------------------------------------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG:0]   rdy;
    logic [NSTG-1:0] en;

    always_comb
    begin
        rdy[NSTG] = out_ready;
        for (int i = NSTG - 1; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
        en[0] = rdy[0] && in_valid;
        for (int i = 1; i < NSTG; i++)
        begin
            en[i] = rdy[i] && vld_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
                vld_reg[0] <= in_valid;
            for (int i = 1; i < NSTG; i++)
            begin
                if (rdy[i])
                    vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NSTG-1];

    // ------------------------------------------------------------------
    // Stage 0: platform masking and shared terms
    // Differential and skid steer drop y; Ackermann drops y and yaw.
    // ------------------------------------------------------------------
    logic signed [VEL_W-1:0]  y_eff;
    logic signed [TURN_W-1:0] w_eff;
    logic signed [TURN_W+SPAN_W:0] tan_full;
    logic signed [LIN_W-1:0]  lin_d_reg, lin_d_next;
    logic signed [LIN_W-1:0]  lin_s_reg, lin_s_next;
    logic signed [TAN_W-1:0]  tan_reg, tan_next;

    always_comb
    begin
        y_eff      = (mode_reg == MODE_MECANUM) ? velocity_y : '0;
        w_eff      = (mode_reg == MODE_ACKERMANN) ? '0 : turn_rate;
        lin_d_next = LIN_W'(velocity_x) - LIN_W'(y_eff);
        lin_s_next = LIN_W'(velocity_x) + LIN_W'(y_eff);
        tan_full   = w_eff * $signed({1'b0, span_reg});
        tan_next   = tan_full[TAN_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            lin_d_reg <= lin_d_next;
            lin_s_reg <= lin_s_next;
            tan_reg   <= tan_next;
        end
    end

    // ------------------------------------------------------------------
    // Wheels: FL = (x-y) - t, FR = (x+y) + t, RL = (x+y) - t, RR = (x-y) + t
    // ------------------------------------------------------------------
    mbik_wheel #(
        .DIV_STEPS (DIV_STEPS_PER_STAGE),
        .NSTG      (NSTG)
    ) u_front_left (
        .clk     (clk),
        .en      (en),
        .cfg     (wcfg),
        .tan_sub (1'b1),
        .lin     (lin_d_reg),
        .tan     (tan_reg),
        .rpm     (front_left_rpm),
        .duty    (front_left_duty)
    );

    mbik_wheel #(
        .DIV_STEPS (DIV_STEPS_PER_STAGE),
        .NSTG      (NSTG)
    ) u_front_right (
        .clk     (clk),
        .en      (en),
        .cfg     (wcfg),
        .tan_sub (1'b0),
        .lin     (lin_s_reg),
        .tan     (tan_reg),
        .rpm     (front_right_rpm),
        .duty    (front_right_duty)
    );

    mbik_wheel #(
        .DIV_STEPS (DIV_STEPS_PER_STAGE),
        .NSTG      (NSTG)
    ) u_rear_left (
        .clk     (clk),
        .en      (en),
        .cfg     (wcfg),
        .tan_sub (1'b1),
        .lin     (lin_s_reg),
        .tan     (tan_reg),
        .rpm     (rear_left_rpm),
        .duty    (rear_left_duty)
    );

    mbik_wheel #(
        .DIV_STEPS (DIV_STEPS_PER_STAGE),
        .NSTG      (NSTG)
    ) u_rear_right (
        .clk     (clk),
        .en      (en),
        .cfg     (wcfg),
        .tan_sub (1'b0),
        .lin     (lin_d_reg),
        .tan     (tan_reg),
        .rpm     (rear_right_rpm),
        .duty    (rear_right_duty)
    );

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    // input side only stalls when every stage holds a beat
    a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (&vld_reg))
        else $error("input stalled with a free pipeline stage");

    // saturation keeps the front left RPM inside the configured limit
    a_rpm_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (front_left_rpm <= $signed({1'b0, max_rpm_reg}))
                   && (-front_left_rpm <= $signed({1'b0, max_rpm_reg})))
        else $error("front left rpm beyond max RPM");

    // rear right duty is zero whenever its RPM is zero
    a_duty_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (rear_right_rpm == '0) |-> (rear_right_duty == '0))
        else $error("rear right duty non-zero at zero rpm");

    a_duty_zero_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (max_rpm_reg == '0) |-> (front_right_duty == '0))
        else $error("duty non-zero with zero max RPM");
`endif

endmodule

/* dv/mobile_base_inverse_kinematics_tb.sv */
// ----------------------------------------------------------------------------
// Mobile base inverse kinematics: self-checking testbench
// Drives velocity commands through the valid/ready input, predicts the four
// wheel RPM targets and PWM duties in fixed point, and checks every result
// beat in order. The configuration is rewritten between phases, and each
// phase runs with one of four patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module mobile_base_inverse_kinematics_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mbik_pkg::*;

    // Nominal pipeline depth of the block with its default parameters
    localparam int PIPE_LATENCY  = 11;
    // Cycles with no beat on either side before the run is called hung
    localparam int IDLE_LIMIT    = 5000;
    localparam int PHASES        = 9;
    localparam int RANDOM_BEATS  = 120;
    // 1000 mm per m times the Q16 scale: divisor that takes gain * speed to RPM
    localparam longint RPM_SCALE = longint'(MS_PER_S) << Q16_SHIFT;

    // Four wheels in port order: front left, front right, rear left, rear right
    typedef struct packed {
        logic [3:0][RPM_W-1:0]  rpm;
        logic [3:0][DUTY_W-1:0] duty;
    } wheel_targets_t;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the registers, works out the wheel
    // targets of every accepted command and matches them against result beats
    // in order.
    // ------------------------------------------------------------------------
    class wheel_target_board;
        platform_mode_t    mode;
        logic [MAX_W-1:0]  max_rpm;
        logic [BITS_W-1:0] pwm_width;
        logic [GAIN_W-1:0] gain;
        logic [SPAN_W-1:0] span;
        wheel_targets_t    pending_targets[$];
        int                mismatches;
        string             wheel_name[4] = '{"front_left", "front_right",
                                             "rear_left", "rear_right"};

        function new();
            // Register values after reset
            mode       = MODE_DIFFERENTIAL;
            max_rpm    = 330;
            pwm_width  = 8;
            gain       = 12516;
            span       = 150;
            mismatches = 0;
        endfunction

        function void set_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_PLATFORM_MODE: mode      = platform_mode_t'(value[MODE_W-1:0]);
                REG_MAX_WHEEL_RPM: max_rpm   = value[MAX_W-1:0];
                REG_PWM_BITS:      pwm_width = value[BITS_W-1:0];
                REG_RPM_GAIN:      gain      = value[GAIN_W-1:0];
                REG_HALF_SPAN:     span      = value[SPAN_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_targets.size();
        endfunction

        // Exact products in 64 bits; division truncates toward zero
        function wheel_targets_t predict_targets(logic signed [VEL_W-1:0] vx,
                                                 logic signed [VEL_W-1:0] vy,
                                                 logic signed [TURN_W-1:0] yaw);
            wheel_targets_t res;
            longint x, y, w, tangential, lin, tn, acc, wheel, lim, full, d;
            int capped;
            x = vx;
            y = vy;
            w = yaw;
            if (mode != MODE_MECANUM)
                y = 0;
            if (mode == MODE_ACKERMANN)
                w = 0;
            tangential = w * longint'(span);
            lim = longint'(max_rpm);
            capped = pwm_width;
            if (capped > FULL_W)
                capped = FULL_W;
            full = (longint'(1) << capped) - 1;
            for (int k = 0; k < 4; k++)
            begin
                // mixes: x-y-t, x+y+t, x+y-t, x-y+t
                lin = (k == 0 || k == 3) ? x - y : x + y;
                tn  = (k == 1 || k == 3) ? tangential : -tangential;
                acc = longint'(gain) * (lin * MS_PER_S + tn);
                wheel = acc / RPM_SCALE;
                if (wheel > lim)
                    wheel = lim;
                if (wheel < -lim)
                    wheel = -lim;
                if (lim == 0)
                    d = 0;
                else
                    d = wheel * full / lim;
                if (d > full)
                    d = full;
                if (d < -full)
                    d = -full;
                res.rpm[k]  = wheel[RPM_W-1:0];
                res.duty[k] = d[DUTY_W-1:0];
            end
            return res;
        endfunction

        function void note_command(logic signed [VEL_W-1:0] vx,
                                   logic signed [VEL_W-1:0] vy,
                                   logic signed [TURN_W-1:0] yaw);
            pending_targets.push_back(predict_targets(vx, vy, yaw));
        endfunction

        function void check_targets(wheel_targets_t got);
            wheel_targets_t want;
            if (pending_targets.size() == 0)
            begin
                $display("%0t: result beat with no command outstanding, got %h",
                         $time, got);
                mismatches++;
                return;
            end
            want = pending_targets.pop_front();
            for (int k = 0; k < 4; k++)
            begin
                if (got.rpm[k] !== want.rpm[k])
                begin
                    $display("%0t: %s_rpm expected %0d, got %0d", $time, wheel_name[k],
                             $signed(want.rpm[k]), $signed(got.rpm[k]));
                    mismatches++;
                end
                if (got.duty[k] !== want.duty[k])
                begin
                    $display("%0t: %s_duty expected %0d, got %0d", $time, wheel_name[k],
                             $signed(want.duty[k]), $signed(got.duty[k]));
                    mismatches++;
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs; every input has a known value from t=0
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                    cfg_write = 1'b0;
    cfg_reg_t                cfg_index = REG_PLATFORM_MODE;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;

    logic                    in_valid   = 1'b0;
    logic                    in_ready;
    logic signed [VEL_W-1:0]  velocity_x = '0;
    logic signed [VEL_W-1:0]  velocity_y = '0;
    logic signed [TURN_W-1:0] turn_rate  = '0;

    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [RPM_W-1:0]  front_left_rpm, front_right_rpm;
    logic signed [RPM_W-1:0]  rear_left_rpm, rear_right_rpm;
    logic signed [DUTY_W-1:0] front_left_duty, front_right_duty;
    logic signed [DUTY_W-1:0] rear_left_duty, rear_right_duty;

    // Per-cycle odds (in percent) of a sender gap and of a receiver stall
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int idle_cycles    = 0;

    // Idling pattern per phase: none, sender only, receiver only, both
    int send_pct_of[4] = '{0, 57, 0, 38};
    int recv_pct_of[4] = '{0, 0, 57, 38};

    // Directed commands: field extremes, each axis alone, all-max and all-min,
    // opposing signs, and small negatives where truncation toward zero differs
    // from flooring.
    int directed[15][3] = '{
        '{0, 0, 0},
        '{8191, 0, 0},
        '{-8192, 0, 0},
        '{0, 8191, 0},
        '{0, -8192, 0},
        '{0, 0, 32767},
        '{0, 0, -32768},
        '{8191, 8191, 32767},
        '{-8192, -8192, -32768},
        '{8191, -8192, 32767},
        '{-8192, 8191, -32768},
        '{1, -1, 1},
        '{-1, 1, -1},
        '{-1000, 0, 0},
        '{100, -50, 300}
    };

    wheel_target_board board;

    always #1 clk = ~clk;

    mobile_base_inverse_kinematics dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .velocity_x       (velocity_x),
        .velocity_y       (velocity_y),
        .turn_rate        (turn_rate),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .front_left_rpm   (front_left_rpm),
        .front_right_rpm  (front_right_rpm),
        .rear_left_rpm    (rear_left_rpm),
        .rear_right_rpm   (rear_right_rpm),
        .front_left_duty  (front_left_duty),
        .front_right_duty (front_right_duty),
        .rear_left_duty   (rear_left_duty),
        .rear_right_duty  (rear_right_duty)
    );

    // ------------------------------------------------------------------------
    // Receiver: ready is redrawn every cycle, so stalls land on any beat
    // ------------------------------------------------------------------------
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // ------------------------------------------------------------------------
    // Monitor: both handshakes are sampled at the edge that completes them.
    // All inputs change by nonblocking assignment, so values seen here are
    // those that were held during the cycle ending at this edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                board.note_command(velocity_x, velocity_y, turn_rate);
            if (out_valid && out_ready)
                board.check_targets('{rpm:  '{rear_right_rpm, rear_left_rpm,
                                              front_right_rpm, front_left_rpm},
                                       duty: '{rear_right_duty, rear_left_duty,
                                              front_right_duty, front_left_duty}});
        end
    end

    // Watchdog: any beat on either side restarts the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Random field value: mostly uniform over the whole range, sometimes an
    // extreme, sometimes small so that results stay clear of saturation.
    function automatic longint rand_field(int width, int spread);
        longint top;
        longint v;
        top = (longint'(1) << (width - 1)) - 1;
        case ($urandom_range(0, 7))
            0:       v = $urandom_range(0, 1) ? top : -top - 1;
            1, 2:    v = longint'($urandom_range(0, 2 * spread)) - spread;
            default: v = longint'($urandom_range(0, 2 * top + 1)) - top - 1;
        endcase
        return v;
    endfunction

    // One command beat; valid stays up from presentation until accepted
    task automatic send_command(logic signed [VEL_W-1:0] vx,
                                logic signed [VEL_W-1:0] vy,
                                logic signed [TURN_W-1:0] yaw);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        velocity_x <= vx;
        velocity_y <= vy;
        turn_rate  <= yaw;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Register write on the next edge; the caller drops cfg_write afterwards
    task automatic write_register(cfg_reg_t idx, int unsigned value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        board.set_register(idx, CFG_DATA_W'(value));
    endtask

    task automatic apply_setting(platform_mode_t mode, int unsigned max_rpm,
                                 int unsigned bits, int unsigned gain,
                                 int unsigned span);
        write_register(REG_PLATFORM_MODE, mode);
        write_register(REG_MAX_WHEEL_RPM, max_rpm);
        write_register(REG_PWM_BITS, bits);
        write_register(REG_RPM_GAIN, gain);
        write_register(REG_HALF_SPAN, span);
    endtask

    // ------------------------------------------------------------------------
    // Sequence: reset, then phases. Each phase changes the registers while the
    // block is empty, sends its commands and drains before the next one.
    // ------------------------------------------------------------------------
    initial
    begin
        board = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            send_idle_pct  = send_pct_of[phase % 4];
            recv_stall_pct = recv_pct_of[phase % 4];
            case (phase)
                // mecanum on top of the reset defaults of the other registers
                0: write_register(REG_PLATFORM_MODE, MODE_MECANUM);
                // top of every register range but PWM bits: hard saturation, 16-bit PWM
                1: apply_setting(MODE_MECANUM, 8191, 16, 24'hFFFFFF, 4095);
                // near the bottom of the ranges: 1 RPM limit, 1-bit PWM, no gain, no span
                2: apply_setting(MODE_MECANUM, 1, 1, 0, 0);
                // zero max RPM, and PWM bits beyond sixteen
                3: apply_setting(MODE_ACKERMANN, 0, 31, 12516, 150);
                // zero PWM bits: full scale of nothing
                4: apply_setting(MODE_SKID_STEER, 330, 0, 12516, 150);
                5: apply_setting(MODE_DIFFERENTIAL, $urandom_range(1, 8191),
                                 $urandom_range(17, 31), $urandom_range(0, 40000),
                                 $urandom_range(0, 4095));
                6: apply_setting(MODE_MECANUM, 8191, 16, 12516, 4095);
                7: apply_setting(platform_mode_t'($urandom_range(0, 3)),
                                 $urandom_range(0, 8191), $urandom_range(0, 31),
                                 $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 4095));
                default: apply_setting(MODE_MECANUM, 2000, 12, 50000, 300);
            endcase
            @(posedge clk);
            cfg_write <= 1'b0;

            if (phase == 0)
                foreach (directed[i])
                    send_command(VEL_W'(directed[i][0]), VEL_W'(directed[i][1]),
                                 TURN_W'(directed[i][2]));
            repeat (RANDOM_BEATS)
                send_command(VEL_W'(rand_field(VEL_W, 300)),
                             VEL_W'(rand_field(VEL_W, 300)),
                             TURN_W'(rand_field(TURN_W, 2000)));
            in_valid <= 1'b0;

            // Empty pipeline before the registers may change again
            do
                @(posedge clk);
            while (board.pending() != 0);
        end

        // Allow for any stray beat the block might still produce
        repeat (4 * PIPE_LATENCY) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
